// ===== src/ssfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfr_pkg
// Shared constants, codes and control types of the segment filter/relabel core.
// ----------------------------------------------------------------------------
package ssfr_pkg;

  localparam int NUM_LABELS = 4096;
  localparam int COUNT_BITS = 24;

  localparam int FUNC_W  = 2;
  localparam int LABEL_W = 12;
  localparam int THR_W   = 24;
  localparam int OUT_W   = 13;

  localparam int ADDR_W = $clog2(NUM_LABELS);
  localparam int TOT_W  = $clog2(NUM_LABELS + 1);
  localparam int CMP_W  = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam int PRE_W  = ADDR_W + 1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MAP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] S_CLR0  = 4'd0;
  localparam logic [STEP_W-1:0] S_CLR1  = 4'd1;
  localparam logic [STEP_W-1:0] S_CLR2  = 4'd2;
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd3;
  localparam logic [STEP_W-1:0] S_SCAN0 = 4'd4;
  localparam logic [STEP_W-1:0] S_SCAN1 = 4'd5;
  localparam logic [STEP_W-1:0] S_SCAN2 = 4'd6;
  localparam logic [STEP_W-1:0] S_SCAN3 = 4'd7;
  localparam logic [STEP_W-1:0] S_CNT   = 4'd8;
  localparam logic [STEP_W-1:0] S_MAP   = 4'd9;
  localparam logic [STEP_W-1:0] S_NOP   = 4'd10;

  localparam logic [1:0] RD_IN   = 2'd0;
  localparam logic [1:0] RD_ITEM = 2'd1;
  localparam logic [1:0] RD_ADDR = 2'd2;

  localparam logic [1:0] OUT_NOP = 2'd0;
  localparam logic [1:0] OUT_CNT = 2'd1;
  localparam logic [1:0] OUT_MAP = 2'd2;

  localparam logic [2:0] COND_NONE      = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_LOOP_ADDR = 3'd2;
  localparam logic [2:0] COND_LOOP_PROC = 3'd3;
  localparam logic [2:0] COND_ITEM      = 3'd4;
  localparam logic [2:0] COND_DISPATCH  = 3'd5;

  typedef struct packed {
    logic       go;
    logic       accept;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       addr_clr;
    logic       addr_inc;
    logic       hist_zero;
    logic       run_clr;
    logic       scan_wr;
    logic       scan_done;
    logic       clr_done;
    logic       emit;
    logic [1:0] out_sel;
  } ctrl_t;

  typedef struct packed {
    logic              in_valid;
    logic              out_full;
    logic              addr_last;
    logic              proc_last;
    logic              have_item;
    logic              total_ok;
    logic              prefix_ok;
    logic [FUNC_W-1:0] in_func;
    logic [FUNC_W-1:0] item_func;
  } stat_t;

endpackage

// ===== src/ssfr_useq.sv =====
// ----------------------------------------------------------------------------
// ssfr_useq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module ssfr_useq import ssfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  typedef struct packed {
    ctrl_t             ops;
    logic              redisp;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic [STEP_W-1:0] pc_inc;
  logic [STEP_W-1:0] disp;
  logic [FUNC_W-1:0] disp_func;
  logic              hold;
  uword_t            uw;

  function automatic logic [STEP_W-1:0] dispatch(input logic [FUNC_W-1:0] func,
                                                 input logic check,
                                                 input logic total_ok,
                                                 input logic prefix_ok);
    logic [STEP_W-1:0] step;
    if (func == FUNC_CLEAR) begin
      step = S_CLR0;
    end else if (check && (!total_ok || (func == FUNC_MAP && !prefix_ok))) begin
      step = S_SCAN0;
    end else begin
      case (func)
        FUNC_COUNT: step = S_CNT;
        FUNC_MAP:   step = S_MAP;
        default:    step = S_NOP;
      endcase
    end
    return step;
  endfunction

  always_comb begin
    uw = '0;
    case (pc)
      S_CLR0: begin
        uw.ops.addr_clr = 1'b1;
        uw.cond         = COND_NONE;
      end
      S_CLR1: begin
        uw.ops.hist_zero = 1'b1;
        uw.ops.addr_inc  = 1'b1;
        uw.cond          = COND_LOOP_ADDR;
        uw.target        = S_CLR1;
      end
      S_CLR2: begin
        uw.ops.clr_done = 1'b1;
        uw.cond         = COND_ITEM;
        uw.target       = S_NOP;
      end
      S_IDLE: begin
        uw.ops.accept = 1'b1;
        uw.ops.rd_en  = 1'b1;
        uw.ops.rd_sel = RD_IN;
        uw.cond       = COND_DISPATCH;
      end
      S_SCAN0: begin
        uw.ops.addr_clr = 1'b1;
        uw.ops.run_clr  = 1'b1;
        uw.cond         = COND_NONE;
      end
      S_SCAN1: begin
        uw.ops.rd_en    = 1'b1;
        uw.ops.rd_sel   = RD_ADDR;
        uw.ops.addr_inc = 1'b1;
        uw.cond         = COND_NONE;
      end
      S_SCAN2: begin
        uw.ops.rd_en    = 1'b1;
        uw.ops.rd_sel   = RD_ADDR;
        uw.ops.addr_inc = 1'b1;
        uw.ops.scan_wr  = 1'b1;
        uw.cond         = COND_LOOP_PROC;
        uw.target       = S_SCAN2;
      end
      S_SCAN3: begin
        uw.ops.scan_done = 1'b1;
        uw.ops.rd_en     = 1'b1;
        uw.ops.rd_sel    = RD_ITEM;
        uw.redisp        = 1'b1;
        uw.cond          = COND_DISPATCH;
      end
      S_CNT: begin
        uw.ops.emit    = 1'b1;
        uw.ops.out_sel = OUT_CNT;
        uw.cond        = COND_ALWAYS;
        uw.target      = S_IDLE;
      end
      S_MAP: begin
        uw.ops.emit    = 1'b1;
        uw.ops.out_sel = OUT_MAP;
        uw.cond        = COND_ALWAYS;
        uw.target      = S_IDLE;
      end
      S_NOP: begin
        uw.ops.emit    = 1'b1;
        uw.ops.out_sel = OUT_NOP;
        uw.cond        = COND_ALWAYS;
        uw.target      = S_IDLE;
      end
      default: begin
        uw.cond   = COND_ALWAYS;
        uw.target = S_IDLE;
      end
    endcase
  end

  assign hold      = (uw.ops.accept && !stat.in_valid) || (uw.ops.emit && stat.out_full);
  assign pc_inc    = pc + STEP_W'(1);
  assign disp_func = uw.redisp ? stat.item_func : stat.in_func;
  assign disp      = dispatch(disp_func, !uw.redisp, stat.total_ok, stat.prefix_ok);

  always_comb begin
    ctrl    = uw.ops;
    ctrl.go = !hold;
  end

  always_comb begin
    case (uw.cond)
      COND_NONE:      pc_next = pc_inc;
      COND_ALWAYS:    pc_next = uw.target;
      COND_LOOP_ADDR: pc_next = stat.addr_last ? pc_inc : uw.target;
      COND_LOOP_PROC: pc_next = stat.proc_last ? pc_inc : uw.target;
      COND_ITEM:      pc_next = stat.have_item ? uw.target : pc_inc;
      COND_DISPATCH:  pc_next = disp;
      default:        pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLR0;
    end else if (!hold) begin
      pc <= pc_next;
    end
  end

endmodule

// ===== src/ssfr_dpath.sv =====
// ----------------------------------------------------------------------------
// ssfr_dpath
// Datapath: histogram and rank memories, sweep counter, kept total, result.
// ----------------------------------------------------------------------------
module ssfr_dpath import ssfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctrl,
  output stat_t                 stat,
  input  logic                  cfg_wr_en,
  input  logic [THR_W-1:0]      cfg_wr_data,
  input  logic                  s_tvalid,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [FUNC_W-1:0]     s_tuser,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(NUM_LABELS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] hist_mem [NUM_LABELS];
  logic [PRE_W-1:0]      pre_mem  [NUM_LABELS];

  logic [THR_W-1:0]      thr;
  logic [FUNC_W-1:0]     item_func;
  logic [LABEL_W-1:0]    item_label;
  logic                  have_item;
  logic                  total_ok;
  logic                  prefix_ok;
  logic [TOT_W-1:0]      total;
  logic [TOT_W-1:0]      total_next;
  logic [TOT_W-1:0]      running;
  logic [ADDR_W-1:0]     addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     rd_addr_q;
  logic [COUNT_BITS-1:0] hist_rd;
  logic [PRE_W-1:0]      pre_rd;

  logic                  rd_go;
  logic                  emit_go;
  logic                  in_range;
  logic [ADDR_W-1:0]     item_addr;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  crossed;
  logic                  scan_kept;
  logic                  hist_we;
  logic [ADDR_W-1:0]     hist_wa;
  logic [COUNT_BITS-1:0] hist_wd;
  logic                  res_kept;
  logic [OUT_W-1:0]      res_new;
  logic [OUT_W-1:0]      res_total;
  logic [TOT_W:0]        total_p1;
  logic [ADDR_W:0]       rank_p1;

  function automatic logic above(input logic [COUNT_BITS-1:0] cnt,
                                 input logic [THR_W-1:0] t);
    return CMP_W'(cnt) > CMP_W'(t);
  endfunction

  assign rd_go     = ctrl.go && ctrl.rd_en;
  assign emit_go   = ctrl.go && ctrl.emit;
  assign in_range  = 32'(item_label) < 32'(NUM_LABELS);
  assign item_addr = ADDR_W'(item_label);

  always_comb begin
    case (ctrl.rd_sel)
      RD_IN:   rd_addr = ADDR_W'(s_tdata[LABEL_W-1:0]);
      RD_ITEM: rd_addr = item_addr;
      default: rd_addr = addr;
    endcase
  end

  assign cnt_new   = (hist_rd != COUNT_MAX) ? hist_rd + COUNT_BITS'(1) : hist_rd;
  assign crossed   = in_range && !above(hist_rd, thr) && above(cnt_new, thr);
  assign scan_kept = above(hist_rd, thr);

  always_comb begin
    hist_we = 1'b0;
    hist_wa = addr;
    hist_wd = '0;
    if (ctrl.go && ctrl.hist_zero) begin
      hist_we = 1'b1;
    end else if (emit_go && ctrl.out_sel == OUT_CNT && in_range) begin
      hist_we = 1'b1;
      hist_wa = item_addr;
      hist_wd = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (rd_go) begin
      hist_rd <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.scan_wr) begin
      pre_mem[rd_addr_q] <= {scan_kept, running[ADDR_W-1:0]};
    end
    if (rd_go) begin
      pre_rd <= pre_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      rd_addr_q <= rd_addr;
    end
    if (ctrl.go && ctrl.addr_clr) begin
      addr <= '0;
    end else if (ctrl.go && ctrl.addr_inc) begin
      addr <= addr + ADDR_W'(1);
    end
    if (ctrl.go && ctrl.run_clr) begin
      running <= '0;
    end else if (ctrl.go && ctrl.scan_wr) begin
      running <= running + TOT_W'(scan_kept);
    end
    if (ctrl.go && ctrl.accept) begin
      item_func  <= s_tuser;
      item_label <= s_tdata[LABEL_W-1:0];
    end
  end

  always_comb begin
    total_next = total;
    if (ctrl.go && ctrl.clr_done) begin
      total_next = '0;
    end else if (ctrl.go && ctrl.scan_done) begin
      total_next = running;
    end else if (emit_go && ctrl.out_sel == OUT_CNT && crossed) begin
      total_next = total + TOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    total <= total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= '0;
      have_item <= 1'b0;
      total_ok  <= 1'b0;
      prefix_ok <= 1'b0;
    end else begin
      if (ctrl.go && ctrl.accept) begin
        have_item <= 1'b1;
      end else if (emit_go) begin
        have_item <= 1'b0;
      end
      if (ctrl.go && ctrl.clr_done) begin
        total_ok  <= 1'b1;
        prefix_ok <= 1'b0;
      end else if (ctrl.go && ctrl.scan_done) begin
        total_ok  <= 1'b1;
        prefix_ok <= 1'b1;
      end else if (emit_go && ctrl.out_sel == OUT_CNT && crossed) begin
        prefix_ok <= 1'b0;
      end
      if (cfg_wr_en) begin
        thr       <= cfg_wr_data;
        total_ok  <= 1'b0;
        prefix_ok <= 1'b0;
      end
    end
  end

  assign total_p1  = {1'b0, total_next} + (TOT_W + 1)'(1);
  assign rank_p1   = {1'b0, pre_rd[ADDR_W-1:0]} + (ADDR_W + 1)'(1);
  assign res_kept  = (ctrl.out_sel == OUT_MAP) && in_range && pre_rd[ADDR_W];
  assign res_new   = res_kept ? OUT_W'(rank_p1) : '0;
  assign res_total = OUT_W'(total_p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit_go) begin
      m_tdata <= OUT_DATA_W'({res_total, res_new, res_kept});
    end
  end

  always_comb begin
    stat.in_valid  = s_tvalid;
    stat.out_full  = m_tvalid && !m_tready;
    stat.addr_last = addr == LAST_ADDR;
    stat.proc_last = rd_addr_q == LAST_ADDR;
    stat.have_item = have_item;
    stat.total_ok  = total_ok;
    stat.prefix_ok = prefix_ok;
    stat.in_func   = s_tuser;
    stat.item_func = item_func;
  end

endmodule

// ===== src/small_segment_filter_relabel_core.sv =====
// ----------------------------------------------------------------------------
// small_segment_filter_relabel_core
// Segment-size filter with dense relabeling, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Channel   Signals                          Contents (lowest bit first)
// s_*       s_tvalid s_tready s_tdata s_tuser tdata: label[11:0]; tuser: func[1:0]
// m_*       m_tvalid m_tready m_tdata         kept[0] new_label[13:1] label_total[26:14]
// cfg_*     cfg_wr_en cfg_wr_data            size_threshold[23:0]
//
// A count, map or no-op transaction is accepted in the idle step, which reads the
// histogram and rank memories, and ends in a result step, which writes back and
// loads the output register. A clear sweeps the histogram, one entry a cycle.
// The first map after counts cross the threshold or after a clear, and the first
// count, map or no-op after a threshold write, rebuild the rank memory.
// After reset the histogram is swept with s_tready low.
// A full output register stalls the sequencer on the result step.
// ----------------------------------------------------------------------------
module small_segment_filter_relabel_core import ssfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [THR_W-1:0]      cfg_wr_data,  // size_threshold
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,      // label[11:0], zero pad
  input  logic [FUNC_W-1:0]     s_tuser,      // func[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata       // kept, new_label[12:0], label_total[12:0]
);

  ctrl_t ctrl;
  stat_t stat;

  assign s_tready = ctrl.accept;

  ssfr_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ssfr_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== src/ssfr_checker.sv =====
// ----------------------------------------------------------------------------
// ssfr_checker
// Port-level checks of the segment filter/relabel core, bound to the top level.
// ----------------------------------------------------------------------------
module ssfr_checker import ssfr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic             out_kept;
  logic [OUT_W-1:0] out_new;
  logic [OUT_W-1:0] out_total;

  assign out_kept  = m_tdata[0];
  assign out_new   = m_tdata[OUT_W:1];
  assign out_total = m_tdata[2*OUT_W:OUT_W+1];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while one is in progress");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_total != '0)
    else $error("label total below one");

  a_kept_rank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kept |-> out_new != '0 && out_new < out_total)
    else $error("kept label outside the kept range");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_kept |-> out_new == '0)
    else $error("dropped label has a nonzero new label");

endmodule

bind small_segment_filter_relabel_core ssfr_checker u_ssfr_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the segment size filter and relabel core. Count, map,
// clear and unused transactions go in with random bursts and gaps, and results
// come out under a changing backpressure pattern. A histogram kept here
// predicts every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ssfr_pkg::*;

  localparam logic [FUNC_W-1:0]     FUNC_UNUSED = 2'd3;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [THR_W-1:0]      THR_MAX     = {THR_W{1'b1}};
  localparam int ITEM_TARGET  = 1850;
  localparam int IDLE_LIMIT   = 60000;
  localparam int LONG_HOLDOFF = 400;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    logic             kept;
    logic [OUT_W-1:0] new_label;
    logic [OUT_W-1:0] label_total;
  } seg_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [THR_W-1:0]      cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // label[11:0], zero pad
  logic [FUNC_W-1:0]     s_tuser = '0;   // func[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // kept, new_label[12:0], label_total[12:0]

  logic [COUNT_BITS-1:0] seg_count [NUM_LABELS];
  logic [THR_W-1:0]      keep_threshold;
  int                    kept_total;
  seg_result_t           relabel_queue [$];
  seg_result_t           want;

  int err_count;
  int items_sent;
  int burst_left;
  bit gaps_on;
  int holdoff_request;
  int holdoff_left;
  int ready_mode;
  int ready_mode_left;
  int ready_phase;
  int idle_cycles;

  small_segment_filter_relabel_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic seg_result_t relabel_predict(input logic [FUNC_W-1:0] func,
                                                  input logic [LABEL_W-1:0] label);
    seg_result_t r;
    int below;
    r = '0;
    if (func == FUNC_COUNT) begin
      if (int'(label) < NUM_LABELS && seg_count[label] != COUNT_MAX) begin
        if (seg_count[label] == keep_threshold) begin
          kept_total++;
        end
        seg_count[label] = seg_count[label] + 1'b1;
      end
    end else if (func == FUNC_CLEAR) begin
      foreach (seg_count[i]) seg_count[i] = '0;
      kept_total = 0;
    end
    r.label_total = OUT_W'(kept_total + 1);
    if (func == FUNC_MAP && int'(label) < NUM_LABELS && seg_count[label] > keep_threshold) begin
      below = 0;
      for (int i = 0; i < int'(label); i++) begin
        if (seg_count[i] > keep_threshold) below++;
      end
      r.kept = 1'b1;
      r.new_label = OUT_W'(below + 1);
    end
    return r;
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [LABEL_W-1:0] label);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(label);
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    relabel_queue = {relabel_queue, relabel_predict(func, label)};
    items_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (relabel_queue.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] value);
    wait_results_drained();
    repeat (10) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    keep_threshold = value;
    kept_total = 0;
    foreach (seg_count[i]) begin
      if (seg_count[i] > keep_threshold) kept_total++;
    end
  endtask

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return THR_MAX;
      2: return THR_W'($urandom());
      3: return THR_W'(1);
      default: return THR_W'($urandom_range(0, 6));
    endcase
  endfunction

  // Sample results and compare with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (relabel_queue.size() == 0) begin
        report_error($sformatf("result with nothing expected, tdata %h", m_tdata));
      end else begin
        want = relabel_queue.pop_front();
        if (m_tdata[0] !== want.kept)
          report_error($sformatf("kept got %0d expected %0d", m_tdata[0], want.kept));
        if (m_tdata[13:1] !== want.new_label)
          report_error($sformatf("new_label got %0d expected %0d",
                                 m_tdata[13:1], want.new_label));
        if (m_tdata[26:14] !== want.label_total)
          report_error($sformatf("label_total got %0d expected %0d",
                                 m_tdata[26:14], want.label_total));
      end
    end
  end

  // Drive result backpressure: long hold-off on request, else a changing pattern
  always @(negedge clk) begin
    if (holdoff_request != 0) begin
      holdoff_left = holdoff_request;
      holdoff_request = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_mode_left = $urandom_range(20, 300);
      end
      ready_mode_left--;
      ready_phase++;
      case (ready_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (ready_phase % 4) != 0;
        default: m_tready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_directed();
    set_threshold('0);
    send_item(FUNC_MAP, 12'd0);
    send_item(FUNC_MAP, 12'hFFF);
    send_item(FUNC_UNUSED, 12'h000);
    send_item(FUNC_COUNT, 12'd0);
    send_item(FUNC_COUNT, 12'hFFF);
    send_item(FUNC_MAP, 12'd0);
    send_item(FUNC_MAP, 12'hFFF);
    send_item(FUNC_MAP, 12'd100);
    send_item(FUNC_COUNT, 12'hFFF);
    send_item(FUNC_UNUSED, 12'hFFF);
    send_item(FUNC_CLEAR, 12'h555);
    send_item(FUNC_MAP, 12'hFFF);
    send_item(FUNC_COUNT, 12'hAAA);
    set_threshold(THR_W'(1));
    send_item(FUNC_COUNT, 12'd7);
    send_item(FUNC_COUNT, 12'd7);
    send_item(FUNC_COUNT, 12'd5);
    send_item(FUNC_MAP, 12'd7);
    send_item(FUNC_MAP, 12'd5);
    send_item(FUNC_MAP, 12'hAAA);
    set_threshold(THR_MAX);
    send_item(FUNC_MAP, 12'd7);
    send_item(FUNC_COUNT, 12'd7);
    send_item(FUNC_CLEAR, 12'hFFF);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    set_threshold(THR_W'(2));
    holdoff_request = LONG_HOLDOFF;
    for (int i = 0; i < 24; i++) begin
      send_item(i < 16 ? FUNC_COUNT : FUNC_MAP, LABEL_W'(i % 5));
    end
    wait_results_drained();
  endtask

  task automatic test_random();
    int pool_base;
    int pool_size;
    int n_count;
    int n_map;
    logic [LABEL_W-1:0] label;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) < 4) set_threshold(pick_threshold());
      if ($urandom_range(0, 1) != 0) send_item(FUNC_CLEAR, LABEL_W'($urandom()));
      pool_base = $urandom_range(0, NUM_LABELS - 1);
      pool_size = $urandom_range(1, 24);
      n_count = $urandom_range(4, 40);
      n_map = $urandom_range(4, 30);
      for (int i = 0; i < n_count + n_map; i++) begin
        label = LABEL_W'(pool_base + $urandom_range(0, pool_size - 1));
        if ($urandom_range(0, 19) == 0) begin
          send_item(FUNC_W'($urandom_range(0, 3)), LABEL_W'($urandom()));
        end else if (i < n_count) begin
          send_item(FUNC_COUNT, label);
        end else if ($urandom_range(0, 7) == 0) begin
          send_item(FUNC_MAP, LABEL_W'($urandom()));
        end else begin
          send_item(FUNC_MAP, label);
        end
      end
    end
  endtask

  initial begin
    foreach (seg_count[i]) seg_count[i] = '0;
    keep_threshold = '0;
    kept_total = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (relabel_queue.size() != 0) begin
      report_error($sformatf("%0d results never arrived", relabel_queue.size()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
